@@ rtl/core/prbq_pkg.sv @@
// package for the packet ring batch queue
// shared widths, reset values, codes and the descriptor record; no dependencies
package prbq_pkg;

    localparam int DEF_QUEUE_SLOTS = 64;
    localparam int DEF_BATCH_SLOTS = 8;

    localparam int SAMPLES_W   = 16;
    localparam int INDEX_W     = 48;
    localparam int SEQ_W       = 32;
    localparam int QS_W        = 7;
    localparam int BS_W        = 4;
    localparam int BUDGET_W    = 20;
    localparam int DEPTH_OUT_W = 7;
    localparam int CNT_W       = 32;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [QS_W-1:0]     RST_QUEUE_SLOTS = 7'd40;
    localparam logic [BS_W-1:0]     RST_BATCH_SLOTS = 4'd1;
    localparam logic [BUDGET_W-1:0] RST_BYTE_BUDGET = 20'd20480;

    localparam logic [1:0] REG_QUEUE_SLOTS = 2'd0;
    localparam logic [1:0] REG_BATCH_SLOTS = 2'd1;
    localparam logic [1:0] REG_BYTE_BUDGET = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_FILL    = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STAT,
        S_FREAD,
        S_FCHK,
        S_EREAD,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic [SAMPLES_W-1:0] samples;
        logic [INDEX_W-1:0]   start_idx;
        logic [INDEX_W-1:0]   end_idx;
        logic [INDEX_W-1:0]   time_us;
        logic                 env;
        logic [SEQ_W-1:0]     seq;
    } t_desc;

endpackage

@@ rtl/core/packet_ring_batch_queue.sv @@
// top level of the packet ring batch queue: apb register file and capacity clamps
// depends on prbq_pkg, prbq_seq and prbq_ram
//
// usage
//   input channel i_in_valid / o_in_stall carries one action per transfer:
//   enqueue a packet descriptor, fill and emit the held batch, or release it.
//   output channel o_out_valid / i_out_stall carries result transfers; a fill
//   with a batch gives one transfer per held packet, o_last on the final one;
//   an empty fill or other action gives a single transfer with o_last set.
//   one action at a time: o_in_stall is high from acceptance until the last
//   result of that action is loaded into the output register.
//   enqueue, release and unknown actions: captured in idle, executed in S_EXEC,
//   result loaded into the output register from S_STAT, then back to idle.
//   fill: per descriptor moved from the ring, one ring memory read (S_FREAD)
//   then check and held memory write (S_FCHK); then per emitted result, a
//   held memory read (S_EREAD) then output load (S_EOUT).
//   a stalled receiver holds the output register and the sequencer waits. reset
//   clears pointers, counters and the batch state; the memories are not cleared
//   and are read only where written. a queue_slots write empties the ring but
//   keeps the batch. user rule, not enforced: config apb writes only while idle.
module packet_ring_batch_queue #(
    parameter int QUEUE_SLOTS = prbq_pkg::DEF_QUEUE_SLOTS,
    parameter int BATCH_SLOTS = prbq_pkg::DEF_BATCH_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_action,
    input  logic [prbq_pkg::SAMPLES_W-1:0]   i_packet_samples,
    input  logic [prbq_pkg::INDEX_W-1:0]     i_start_sample_index,
    input  logic [prbq_pkg::INDEX_W-1:0]     i_end_sample_index,
    input  logic [prbq_pkg::INDEX_W-1:0]     i_start_time_us,
    input  logic                             i_has_env,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic                             o_entry_valid,
    output logic [prbq_pkg::SEQ_W-1:0]       o_sequence_res,
    output logic [prbq_pkg::SAMPLES_W-1:0]   o_out_samples,
    output logic [prbq_pkg::INDEX_W-1:0]     o_out_start_index,
    output logic [prbq_pkg::INDEX_W-1:0]     o_out_end_index,
    output logic [prbq_pkg::INDEX_W-1:0]     o_out_time_us,
    output logic                             o_out_env,
    output logic                             o_last,
    output logic [prbq_pkg::DEPTH_OUT_W-1:0] o_queue_depth,
    output logic [prbq_pkg::CNT_W-1:0]       o_overflow_count,
    output logic [prbq_pkg::DEPTH_OUT_W-1:0] o_high_water,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prbq_pkg::PADDR_W-1:0]     paddr,
    input  logic [prbq_pkg::PDATA_W-1:0]     pwdata,
    output logic [prbq_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import prbq_pkg::*;

    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam int HW = $clog2(BATCH_SLOTS + 1);

    logic [QS_W-1:0]     r_queue_slots;
    logic [BS_W-1:0]     r_batch_slots;
    logic [BUDGET_W-1:0] r_byte_budget;

    logic                wr_en, flush;
    logic [1:0]          reg_idx;
    logic [CW-1:0]       cap;
    logic [HW-1:0]       bmax;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign flush   = wr_en && (reg_idx == REG_QUEUE_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_slots <= RST_QUEUE_SLOTS;
            r_batch_slots <= RST_BATCH_SLOTS;
            r_byte_budget <= RST_BYTE_BUDGET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_QUEUE_SLOTS: r_queue_slots <= pwdata[QS_W-1:0];
                REG_BATCH_SLOTS: r_batch_slots <= pwdata[BS_W-1:0];
                REG_BYTE_BUDGET: r_byte_budget <= pwdata[BUDGET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_QUEUE_SLOTS: prdata = PDATA_W'(r_queue_slots);
            REG_BATCH_SLOTS: prdata = PDATA_W'(r_batch_slots);
            REG_BYTE_BUDGET: prdata = PDATA_W'(r_byte_budget);
            default:         prdata = '0;
        endcase
    end

    // effective ring and batch capacities
    always_comb begin
        priority if (r_queue_slots == '0) begin
            cap = CW'(1);
        end else if (int'(r_queue_slots) > QUEUE_SLOTS) begin
            cap = CW'(QUEUE_SLOTS);
        end else begin
            cap = CW'(r_queue_slots);
        end

        priority if (r_batch_slots == '0) begin
            bmax = HW'(1);
        end else if (int'(r_batch_slots) > BATCH_SLOTS) begin
            bmax = HW'(BATCH_SLOTS);
        end else begin
            bmax = HW'(r_batch_slots);
        end
    end

    prbq_seq #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .BATCH_SLOTS (BATCH_SLOTS)
    ) u_seq (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_action             (i_action),
        .i_packet_samples     (i_packet_samples),
        .i_start_sample_index (i_start_sample_index),
        .i_end_sample_index   (i_end_sample_index),
        .i_start_time_us      (i_start_time_us),
        .i_has_env            (i_has_env),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_accepted           (o_accepted),
        .o_entry_valid        (o_entry_valid),
        .o_sequence_res       (o_sequence_res),
        .o_out_samples        (o_out_samples),
        .o_out_start_index    (o_out_start_index),
        .o_out_end_index      (o_out_end_index),
        .o_out_time_us        (o_out_time_us),
        .o_out_env            (o_out_env),
        .o_last               (o_last),
        .o_queue_depth        (o_queue_depth),
        .o_overflow_count     (o_overflow_count),
        .o_high_water         (o_high_water),
        .i_cap                (cap),
        .i_bmax               (bmax),
        .i_budget             (r_byte_budget),
        .i_flush              (flush)
    );

endmodule

@@ rtl/core/prbq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module prbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/prbq_seq.sv @@
// queue sequencer: ring and held-batch memories, pointers, counters, output register
// depends on prbq_pkg and prbq_ram
module prbq_seq #(
    parameter int QUEUE_SLOTS = prbq_pkg::DEF_QUEUE_SLOTS,
    parameter int BATCH_SLOTS = prbq_pkg::DEF_BATCH_SLOTS,
    localparam int CW = $clog2(QUEUE_SLOTS + 1),
    localparam int HW = $clog2(BATCH_SLOTS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_action,
    input  logic [prbq_pkg::SAMPLES_W-1:0]       i_packet_samples,
    input  logic [prbq_pkg::INDEX_W-1:0]         i_start_sample_index,
    input  logic [prbq_pkg::INDEX_W-1:0]         i_end_sample_index,
    input  logic [prbq_pkg::INDEX_W-1:0]         i_start_time_us,
    input  logic                                 i_has_env,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_accepted,
    output logic                                 o_entry_valid,
    output logic [prbq_pkg::SEQ_W-1:0]           o_sequence_res,
    output logic [prbq_pkg::SAMPLES_W-1:0]       o_out_samples,
    output logic [prbq_pkg::INDEX_W-1:0]         o_out_start_index,
    output logic [prbq_pkg::INDEX_W-1:0]         o_out_end_index,
    output logic [prbq_pkg::INDEX_W-1:0]         o_out_time_us,
    output logic                                 o_out_env,
    output logic                                 o_last,
    output logic [prbq_pkg::DEPTH_OUT_W-1:0]     o_queue_depth,
    output logic [prbq_pkg::CNT_W-1:0]           o_overflow_count,
    output logic [prbq_pkg::DEPTH_OUT_W-1:0]     o_high_water,
    input  logic [CW-1:0]                        i_cap,
    input  logic [HW-1:0]                        i_bmax,
    input  logic [prbq_pkg::BUDGET_W-1:0]        i_budget,
    input  logic                                 i_flush
);
    import prbq_pkg::*;

    localparam int QW     = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int BW     = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
    localparam int DW     = $clog2(QUEUE_SLOTS + BATCH_SLOTS + 1);
    localparam int BYTE_W = (SAMPLES_W + 1 + HW > BUDGET_W) ? SAMPLES_W + 1 + HW : BUDGET_W;
    localparam int DESC_W = $bits(t_desc);

    t_state                r_state, n_state;
    t_action               r_action;
    logic [SAMPLES_W-1:0]  r_samples;
    logic [INDEX_W-1:0]    r_start, r_end, r_time;
    logic                  r_env;

    logic [QW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [SEQ_W-1:0]      r_seq_next, n_seq_next;
    logic [HW-1:0]         r_hcount, n_hcount;
    logic                  r_hvalid, n_hvalid;
    logic [CNT_W-1:0]      r_drop, n_drop;
    logic [DW-1:0]         r_peak, n_peak;
    logic [BYTE_W-1:0]     r_bytes, n_bytes;
    logic [HW-1:0]         r_idx, n_idx;
    logic                  r_res_acc, n_res_acc;
    logic [SEQ_W-1:0]      r_res_seq, n_res_seq;

    logic                  r_out_valid;
    logic                  r_out_acc, r_out_ev, r_out_last;
    logic [SEQ_W-1:0]      r_out_seq;
    t_desc                 r_out_desc;
    logic [DEPTH_OUT_W-1:0] r_out_depth, r_out_peak;
    logic [CNT_W-1:0]      r_out_drop;

    logic                  out_free, out_load, ld_acc, ld_ev, ld_last;
    logic [SEQ_W-1:0]      ld_seq;
    t_desc                 ld_desc;

    logic                  ring_we, ring_re, held_we, held_re;
    logic [QW-1:0]         ring_waddr;
    t_desc                 ring_wdesc, ring_rdesc, held_rdesc;
    logic [DESC_W-1:0]     ring_rdata, held_rdata;

    logic [DW-1:0]         eff;
    logic                  enq_ok, full;
    logic [CW-1:0]         head_p1, count_a;
    logic [QW-1:0]         head_inc, head_a;
    logic [CW:0]           wsum;
    logic [DW-1:0]         eff_enq;
    logic [CNT_W-1:0]      drop_a;
    logic [BYTE_W:0]       byte_sum;
    logic                  over;

    assign ring_rdesc = t_desc'(ring_rdata);
    assign held_rdesc = t_desc'(held_rdata);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        eff = DW'(r_count) + (r_hvalid ? DW'(r_hcount) : DW'(0));

        enq_ok   = (r_samples != '0) && (r_end > r_start);
        full     = (r_count >= i_cap);
        head_p1  = CW'(r_head) + CW'(1);
        head_inc = (head_p1 == i_cap) ? '0 : QW'(head_p1);
        head_a   = full ? head_inc : r_head;
        count_a  = full ? (i_cap - CW'(1)) : r_count;
        drop_a   = (full && r_drop != CNT_MAX) ? r_drop + CNT_W'(1) : r_drop;
        wsum     = (CW + 1)'(head_a) + (CW + 1)'(count_a);
        if (wsum >= (CW + 1)'(i_cap)) begin
            wsum = wsum - (CW + 1)'(i_cap);
        end
        ring_waddr = QW'(wsum);
        eff_enq    = DW'(count_a) + DW'(1) + (r_hvalid ? DW'(r_hcount) : DW'(0));

        byte_sum = (BYTE_W + 1)'(r_bytes) + (BYTE_W + 1)'({ring_rdesc.samples, 1'b0});
        over     = (r_hcount != '0) && (byte_sum > (BYTE_W + 1)'(i_budget));
    end

    always_comb begin
        ring_wdesc.samples   = r_samples;
        ring_wdesc.start_idx = r_start;
        ring_wdesc.end_idx   = r_end;
        ring_wdesc.time_us   = r_time;
        ring_wdesc.env       = r_env;
        ring_wdesc.seq       = r_seq_next;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_seq_next = r_seq_next;
        n_hcount   = r_hcount;
        n_hvalid   = r_hvalid;
        n_drop     = r_drop;
        n_peak     = r_peak;
        n_bytes    = r_bytes;
        n_idx      = r_idx;
        n_res_acc  = r_res_acc;
        n_res_seq  = r_res_seq;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        held_we    = 1'b0;
        held_re    = 1'b0;
        out_load   = 1'b0;
        ld_acc     = 1'b0;
        ld_ev      = 1'b0;
        ld_last    = 1'b1;
        ld_seq     = r_res_seq;
        ld_desc    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state   = S_STAT;
                n_res_acc = 1'b0;
                n_res_seq = '0;
                case (r_action)
                    ACT_ENQUEUE: begin
                        if (enq_ok) begin
                            ring_we    = 1'b1;
                            n_head     = head_a;
                            n_count    = count_a + CW'(1);
                            n_drop     = drop_a;
                            n_seq_next = r_seq_next + SEQ_W'(1);
                            n_res_acc  = 1'b1;
                            n_res_seq  = r_seq_next;
                            if (eff_enq > r_peak) begin
                                n_peak = eff_enq;
                            end
                        end
                    end
                    ACT_FILL: begin
                        if (r_hvalid) begin
                            n_idx   = '0;
                            n_state = S_EREAD;
                        end else begin
                            n_hcount = '0;
                            n_bytes  = '0;
                            n_state  = S_FREAD;
                        end
                    end
                    ACT_RELEASE: begin
                        n_res_acc = r_hvalid;
                        n_hcount  = '0;
                        n_hvalid  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_STAT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_acc   = r_res_acc;
                    n_state  = S_IDLE;
                end
            end
            S_FREAD: begin
                if (r_count != '0 && r_hcount < i_bmax) begin
                    ring_re = 1'b1;
                    n_state = S_FCHK;
                end else if (r_hcount != '0) begin
                    n_hvalid = 1'b1;
                    n_idx    = '0;
                    n_state  = S_EREAD;
                end else begin
                    n_res_acc = 1'b0;
                    n_res_seq = '0;
                    n_state   = S_STAT;
                end
            end
            S_FCHK: begin
                if (over) begin
                    n_hvalid = 1'b1;
                    n_idx    = '0;
                    n_state  = S_EREAD;
                end else begin
                    held_we  = 1'b1;
                    n_bytes  = BYTE_W'(byte_sum);
                    n_hcount = r_hcount + HW'(1);
                    n_head   = head_inc;
                    n_count  = r_count - CW'(1);
                    n_state  = S_FREAD;
                end
            end
            S_EREAD: begin
                held_re = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_acc   = 1'b1;
                    ld_ev    = 1'b1;
                    ld_desc  = held_rdesc;
                    ld_seq   = held_rdesc.seq;
                    ld_last  = (r_idx + HW'(1) == r_hcount);
                    n_idx    = r_idx + HW'(1);
                    n_state  = ld_last ? S_IDLE : S_EREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // queue_slots write empties the ring
        if (i_flush) begin
            n_head  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_seq_next <= '0;
            r_hcount   <= '0;
            r_hvalid   <= 1'b0;
            r_drop     <= '0;
            r_peak     <= '0;
            r_bytes    <= '0;
            r_idx      <= '0;
            r_res_acc  <= 1'b0;
            r_res_seq  <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_seq_next <= n_seq_next;
            r_hcount   <= n_hcount;
            r_hvalid   <= n_hvalid;
            r_drop     <= n_drop;
            r_peak     <= n_peak;
            r_bytes    <= n_bytes;
            r_idx      <= n_idx;
            r_res_acc  <= n_res_acc;
            r_res_seq  <= n_res_seq;
        end
    end

    // captured input item
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action  <= t_action'(i_action);
            r_samples <= i_packet_samples;
            r_start   <= i_start_sample_index;
            r_end     <= i_end_sample_index;
            r_time    <= i_start_time_us;
            r_env     <= i_has_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_acc   <= ld_acc;
            r_out_ev    <= ld_ev;
            r_out_last  <= ld_last;
            r_out_seq   <= ld_seq;
            r_out_desc  <= ld_desc;
            r_out_depth <= DEPTH_OUT_W'(eff);
            r_out_drop  <= r_drop;
            r_out_peak  <= DEPTH_OUT_W'(r_peak);
        end
    end

    prbq_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdesc),
        .i_re    (ring_re),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    prbq_ram #(
        .WIDTH (DESC_W),
        .DEPTH (BATCH_SLOTS)
    ) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (held_we),
        .i_waddr (r_hcount[BW-1:0]),
        .i_wdata (ring_rdesc),
        .i_re    (held_re),
        .i_raddr (r_idx[BW-1:0]),
        .o_rdata (held_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_out_acc;
    assign o_entry_valid     = r_out_ev;
    assign o_sequence_res    = r_out_seq;
    assign o_out_samples     = r_out_desc.samples;
    assign o_out_start_index = r_out_desc.start_idx;
    assign o_out_end_index   = r_out_desc.end_idx;
    assign o_out_time_us     = r_out_desc.time_us;
    assign o_out_env         = r_out_desc.env;
    assign o_last            = r_out_last;
    assign o_queue_depth     = r_out_depth;
    assign o_overflow_count  = r_out_drop;
    assign o_high_water      = r_out_peak;

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i_cap)
        else $error("ring count beyond capacity");

    a_head_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_head) < i_cap)
        else $error("ring head beyond capacity");

    a_held_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hvalid |-> (r_hcount != '0))
        else $error("held batch marked valid but empty");

    a_emit_needs_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT) |-> (r_hvalid && r_idx < r_hcount))
        else $error("batch emission without a held entry");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHK) |-> ($past(r_state) == S_FREAD && $past(r_count) != '0))
        else $error("ring check without a ring read");

endmodule
